@@ rtl/core/sorted_laxity_sum_unsafe_test_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted laxity sum unsafe test
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SORTED_LAXITY_SUM_UNSAFE_TEST_ASSERT_SVH
`define SORTED_LAXITY_SUM_UNSAFE_TEST_ASSERT_SVH

`ifndef SYNTHESIS
// plain property, checked while out of reset
`define SLSU_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("slsu assertion failed");
// implication: cond holds in the same cycle as trig
`define SLSU_ASSERT_IMPL(name, clk, rst_n, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("slsu assertion failed");
`else
`define SLSU_ASSERT(name, clk, rst_n, prop)
`define SLSU_ASSERT_IMPL(name, clk, rst_n, trig, cond)
`endif

`endif

@@ rtl/core/slsu_pkg.sv @@
// ----------------------------------------------------------------------------
// slsu_pkg
// Shared types and constants for the sorted laxity sum unsafe test.
// ----------------------------------------------------------------------------
`default_nettype none

package slsu_pkg;

    localparam int MAX_JOBS    = 64;
    localparam int LAXITY_BITS = 16;
    // running margin t = sum - (k - 2); room for MAX_JOBS laxities plus sign
    localparam int T_W         = LAXITY_BITS + $clog2(MAX_JOBS) + 2;
    localparam int ADDR_W      = 3;

    typedef logic signed [LAXITY_BITS-1:0] lax_t;
    typedef logic signed [T_W-1:0]         margin_t;

    localparam margin_t T_START = margin_t'(2);

    // cell commands
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // register indexes (paddr[2])
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_CRIT = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        lax_t       x;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic gt;       // valid and holds a value greater than the insert value
        lax_t val;
    } cell_link_t;

    typedef struct packed {
        logic busy;
        logic shift;
        logic clear;
    } scan_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/slsu_cell.sv @@
// ----------------------------------------------------------------------------
// slsu_cell
// One slot of the sorted insertion chain: inserts, shifts down, or clears.
// ----------------------------------------------------------------------------
`default_nettype none

module slsu_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  slsu_pkg::cell_cmd_t     cmd,
    input  slsu_pkg::cell_link_t    left,
    input  slsu_pkg::cell_link_t    right,
    output slsu_pkg::cell_link_t    self_link
);

    logic             valid_reg;
    logic             valid_next;
    slsu_pkg::lax_t   val_reg;
    slsu_pkg::lax_t   val_next;
    logic             gt;

    assign gt = valid_reg && (val_reg > cmd.x);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        case (cmd.op)
            slsu_pkg::OP_INSERT:
            begin
                // entries at or below x stay; bigger ones move up one slot
                valid_next = valid_reg | left.valid;
                if (left.gt)
                begin
                    val_next = left.val;
                end
                else if (gt || !valid_reg)
                begin
                    val_next = cmd.x;
                end
            end
            slsu_pkg::OP_SHIFT:
            begin
                valid_next = right.valid;
                val_next   = right.val;
            end
            slsu_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign self_link.valid = valid_reg;
    assign self_link.gt    = gt;
    assign self_link.val   = val_reg;

endmodule

`default_nettype wire

@@ rtl/core/slsu_scan.sv @@
// ----------------------------------------------------------------------------
// slsu_scan
// Prefix-sum scan over the chain head, one entry per cycle, and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module slsu_scan (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     go,
    input  slsu_pkg::cell_link_t    head,
    input  wire                     ovf_in,
    output slsu_pkg::scan_ctl_t     ctl,
    output logic                    done,
    output logic                    unsafe,
    output logic                    overflow
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic               state_reg;
    logic               state_next;
    slsu_pkg::margin_t  t_reg;
    slsu_pkg::margin_t  t_next;
    slsu_pkg::margin_t  t_sum;
    logic               t_fail;
    logic               done_reg;
    logic               done_next;
    logic               unsafe_reg;
    logic               unsafe_next;
    logic               ovf_reg;
    logic               ovf_next;

    // t tracks sum - (k - 2); each step adds laxity - 1
    assign t_sum  = t_reg
                  + {{(slsu_pkg::T_W - slsu_pkg::LAXITY_BITS){head.val[slsu_pkg::LAXITY_BITS-1]}},
                     head.val}
                  - slsu_pkg::margin_t'(1);
    assign t_fail = t_sum[slsu_pkg::T_W-1] || (t_sum == '0);

    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        done_next   = 1'b0;
        unsafe_next = unsafe_reg;
        ovf_next    = ovf_reg;
        ctl.busy    = (state_reg == ST_SCAN);
        ctl.shift   = 1'b0;
        ctl.clear   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_SCAN;
                    t_next     = slsu_pkg::T_START;
                end
            end
            ST_SCAN:
            begin
                if (!head.valid || t_fail)
                begin
                    ctl.clear   = 1'b1;
                    done_next   = 1'b1;
                    unsafe_next = head.valid;
                    ovf_next    = ovf_in;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctl.shift = 1'b1;
                    t_next    = t_sum;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            unsafe_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            unsafe_reg <= unsafe_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

    assign done     = done_reg;
    assign unsafe   = unsafe_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

@@ rtl/core/sorted_laxity_sum_unsafe_test.sv @@
// A qualifying job beat is inserted into the registered sorted chain; jobs stream 1 per cycle while busy is low.
// After the last beat, busy rises and the chain is scanned one entry per cycle from its head;
// done pulses once the scan runs past the n stored entries (sooner on an early unsafe).
// Each tested state adds a scan during which busy is high and no job beat is accepted.
// The result beat lasts one cycle and cannot be stalled by the receiver.
// Reset (rst_n low, async): chain empty, overflow flag clear, mode and system_crit zero.
`default_nettype none
`include "sorted_laxity_sum_unsafe_test_assert.svh"

// ----------------------------------------------------------------------------
// sorted_laxity_sum_unsafe_test
// Sorted insertion chain of job laxities with a prefix-sum unsafe check.
// ----------------------------------------------------------------------------
module sorted_laxity_sum_unsafe_test (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 active,
    input  wire                                 job_crit,
    input  wire signed [slsu_pkg::LAXITY_BITS-1:0] laxity,
    input  wire signed [slsu_pkg::LAXITY_BITS-1:0] wc_laxity,
    input  wire                                 last,
    output logic                                done,
    output logic                                unsafe,
    output logic                                overflow,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [slsu_pkg::ADDR_W-1:0]         paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic                   mode_reg;
    logic                   crit_reg;
    logic                   ovfl_reg;
    logic                   ovfl_next;
    logic                   cfg_wr;
    logic                   accept;
    logic                   qualify;
    logic                   full;
    logic                   scan_go;
    slsu_pkg::cell_cmd_t    cmd;
    slsu_pkg::scan_ctl_t    ctl;
    slsu_pkg::cell_link_t   link      [slsu_pkg::MAX_JOBS];
    slsu_pkg::cell_link_t   left_link [slsu_pkg::MAX_JOBS];
    slsu_pkg::cell_link_t   right_link[slsu_pkg::MAX_JOBS];
    logic [slsu_pkg::MAX_JOBS-1:0] valid_vec;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            crit_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == slsu_pkg::REG_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            else
            begin
                crit_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            slsu_pkg::REG_MODE: prdata = {31'b0, mode_reg};
            slsu_pkg::REG_CRIT: prdata = {31'b0, crit_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- job intake ----------------
    assign busy    = ctl.busy;
    assign accept  = start && !busy;
    assign qualify = active && (!mode_reg || job_crit || !crit_reg);
    assign full    = link[slsu_pkg::MAX_JOBS-1].valid;
    assign scan_go = accept && last;

    always_comb
    begin
        cmd.x  = mode_reg ? wc_laxity : laxity;
        if (ctl.clear)
        begin
            cmd.op = slsu_pkg::OP_CLEAR;
        end
        else if (ctl.shift)
        begin
            cmd.op = slsu_pkg::OP_SHIFT;
        end
        else if (accept && qualify && !full)
        begin
            cmd.op = slsu_pkg::OP_INSERT;
        end
        else
        begin
            cmd.op = slsu_pkg::OP_HOLD;
        end
    end

    always_comb
    begin
        ovfl_next = ovfl_reg;
        if (ctl.clear)
        begin
            ovfl_next = 1'b0;
        end
        else if (accept && qualify && full)
        begin
            ovfl_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovfl_reg <= 1'b0;
        end
        else
        begin
            ovfl_reg <= ovfl_next;
        end
    end

    // ---------------- insertion chain ----------------
    always_comb
    begin
        for (int i = 0; i < slsu_pkg::MAX_JOBS; i++)
        begin
            valid_vec[i] = link[i].valid;
            if (i == 0)
            begin
                left_link[i].valid = 1'b1;
                left_link[i].gt    = 1'b0;
                left_link[i].val   = '0;
            end
            else
            begin
                left_link[i] = link[i-1];
            end
            if (i == slsu_pkg::MAX_JOBS - 1)
            begin
                right_link[i].valid = 1'b0;
                right_link[i].gt    = 1'b0;
                right_link[i].val   = link[i].val;
            end
            else
            begin
                right_link[i] = link[i+1];
            end
        end
    end

    for (genvar g = 0; g < slsu_pkg::MAX_JOBS; g++)
    begin : g_cell
        slsu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left      (left_link[g]),
            .right     (right_link[g]),
            .self_link (link[g])
        );
    end

    // ---------------- scan ----------------
    slsu_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (scan_go),
        .head     (link[0]),
        .ovf_in   (ovfl_reg),
        .ctl      (ctl),
        .done     (done),
        .unsafe   (unsafe),
        .overflow (overflow)
    );

    // ---------------- checks ----------------
    `SLSU_ASSERT_IMPL(a_done_not_busy, clk, rst_n, done, !busy)
    `SLSU_ASSERT_IMPL(a_done_after_scan, clk, rst_n, done, $past(busy))
    `SLSU_ASSERT(a_last_starts_scan, clk, rst_n, scan_go |=> busy)
    `SLSU_ASSERT(a_chain_packed, clk, rst_n, ((valid_vec >> 1) & ~valid_vec) == '0)

endmodule

`default_nettype wire
